[design/item_id_visibility_histogram_macros.svh]
// Assertion macros for the item ID visibility histogram checker.
`ifndef ITEM_ID_VISIBILITY_HISTOGRAM_MACROS_SVH
`define ITEM_ID_VISIBILITY_HISTOGRAM_MACROS_SVH
// same-cycle implication, sampled on clk, off during reset
`define IVH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication, sampled on clk, off during reset
`define IVH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[design/ivh_pkg.sv]
// Shared types, codes and constants of the item ID visibility histogram.
package ivh_pkg;
	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;
	localparam int DEF_BIN_COUNT  = 4096;
	localparam int GROUP_BITS     = 6;
	localparam int MEMBER_BITS    = 6;
	localparam int COUNT_BITS     = 21;
	localparam int ID_W           = 32;
	localparam int DIM_W          = 14;
	localparam int JBIN_W         = 16;
	localparam int BIN_PORT_W     = 12;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;

	localparam logic [ID_W-1:0] NULL_ID = '1;

	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] ST_COUNTED = 3'd0;
	localparam logic [2:0] ST_NULL    = 3'd1;
	localparam logic [2:0] ST_BORDER  = 3'd2;
	localparam logic [2:0] ST_RANGE   = 3'd3;
	localparam logic [2:0] ST_READ    = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	localparam logic [1:0] OP_PASS  = 2'd0;
	localparam logic [1:0] OP_COUNT = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;
	localparam logic [1:0] OP_CLEAR = 2'd3;

	localparam logic [2:0] REG_CONS   = 3'd0;
	localparam logic [2:0] REG_LAYOUT = 3'd1;
	localparam logic [2:0] REG_WIDTH  = 3'd2;
	localparam logic [2:0] REG_HEIGHT = 3'd3;
	localparam logic [2:0] REG_ITEMS  = 3'd4;
	localparam logic [2:0] REG_GROUPS = 3'd5;
	localparam logic [2:0] REG_MEMBERS = 3'd6;

	typedef struct packed {
		logic [1:0]        op;
		logic [2:0]        status;
		logic [JBIN_W-1:0] bin;
		logic              frame_end;
	} job_t;

	typedef struct packed {
		logic        conservative;
		logic        two_level;
		logic [10:0] width;
		logic [10:0] height;
		logic [12:0] item_limit;
		logic [6:0]  group_limit;
		logic [6:0]  member_limit;
	} cfg_t;
endpackage

[design/ivh_front.sv]
// Front end: accepts words, runs the line buffers and classifies each item into a job.
module ivh_front #(
	parameter int MAX_WIDTH  = ivh_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ivh_pkg::DEF_MAX_HEIGHT,
	parameter int BIN_COUNT  = ivh_pkg::DEF_BIN_COUNT
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ivh_pkg::cfg_t             cfg,
	input  logic                      push,
	output logic                      full,
	input  logic [1:0]                kind,
	input  logic [ivh_pkg::ID_W-1:0]  pixel_id,
	input  logic [11:0]               bin_index,
	input  logic                      hold,
	input  logic                      q_full,
	output logic                      q_push,
	output ivh_pkg::job_t             q_job
);
	import ivh_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam logic F_IDLE = 1'b0;
	localparam logic F_EVAL = 1'b1;

	logic [ID_W-1:0] row_one_q [MAX_WIDTH];
	logic [ID_W-1:0] row_two_q [MAX_WIDTH];
	logic            state_q;
	logic [ID_W-1:0] id_s1;
	logic [ID_W-1:0] above_q, two_q;
	logic [ID_W-1:0] mt0_q, mt1_q, mt2_q, up_q, cur_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   row_q;
	logic            accept;
	logic [DIM_W-1:0] w_eff, h_eff, fw_ext, fh_ext, col_inc, row_inc;
	logic            col_wrap, row_wrap;
	logic [ID_W-1:0] cand;
	logic [ID_W-1:0] grp, mem, bin2, mbin;
	logic            valid;
	job_t            pix_job, cmd_job;

	assign full   = (state_q != F_IDLE) || q_full || hold;
	assign accept = push && !full;

	always_ff @(posedge clk) begin
		if (accept) begin
			above_q <= row_one_q[col_q];
			two_q   <= row_two_q[col_q];
			id_s1   <= pixel_id;
		end
		if (state_q == F_EVAL) begin
			row_one_q[col_q] <= id_s1;
			row_two_q[col_q] <= above_q;
		end
	end

	always_comb begin
		fw_ext  = DIM_W'(cfg.width);
		fh_ext  = DIM_W'(cfg.height);
		w_eff   = (fw_ext == '0) ? DIM_W'(1) :
			((fw_ext > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : fw_ext);
		h_eff   = (fh_ext == '0) ? DIM_W'(1) :
			((fh_ext > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : fh_ext);
		col_inc  = DIM_W'(col_q) + DIM_W'(1);
		row_inc  = DIM_W'(row_q) + DIM_W'(1);
		col_wrap = col_inc >= w_eff;
		row_wrap = row_inc >= h_eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			mt0_q   <= NULL_ID;
			mt1_q   <= NULL_ID;
			mt2_q   <= NULL_ID;
			up_q    <= NULL_ID;
			cur_q   <= NULL_ID;
			col_q   <= '0;
			row_q   <= '0;
		end else if (state_q == F_EVAL) begin
			state_q <= F_IDLE;
			mt0_q   <= above_q;
			mt1_q   <= mt0_q;
			mt2_q   <= mt1_q;
			up_q    <= two_q;
			cur_q   <= id_s1;
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_inc[RW-1:0];
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end else if (accept && kind == KIND_PIXEL) begin
			state_q <= F_EVAL;
		end
	end

	always_comb begin
		cand = cfg.conservative ? mt0_q : id_s1;
		grp  = {16'd0, cand[15:0]};
		mem  = {16'd0, cand[31:16]};
		bin2 = (grp << MEMBER_BITS) | mem;
		if (cfg.two_level) begin
			valid = (grp < ID_W'(cfg.group_limit)) && (mem < ID_W'(cfg.member_limit))
				&& (grp < ID_W'(64'(1) << GROUP_BITS))
				&& (mem < ID_W'(64'(1) << MEMBER_BITS))
				&& (bin2 < ID_W'(BIN_COUNT));
			mbin  = bin2;
		end else begin
			valid = (cand < ID_W'(cfg.item_limit)) && (cand < ID_W'(BIN_COUNT));
			mbin  = cand;
		end

		pix_job           = '0;
		pix_job.op        = OP_PASS;
		pix_job.frame_end = col_wrap && row_wrap;
		if (cfg.conservative && (row_q < RW'(2) || col_q < CW'(2))) begin
			pix_job.status = ST_BORDER;
		end else if (cand == NULL_ID) begin
			pix_job.status = ST_NULL;
		end else if (cfg.conservative && (up_q != mt0_q || cur_q != mt0_q ||
				mt1_q != mt0_q || above_q != mt0_q)) begin
			pix_job.status = ST_BORDER;
		end else if (!valid) begin
			pix_job.status = ST_RANGE;
		end else begin
			pix_job.op     = OP_COUNT;
			pix_job.status = ST_COUNTED;
			pix_job.bin    = mbin[JBIN_W-1:0];
		end

		cmd_job = '0;
		if (kind == KIND_CLEAR) begin
			cmd_job.op     = OP_CLEAR;
			cmd_job.status = ST_CLEARED;
		end else begin
			cmd_job.bin = JBIN_W'(bin_index);
			if (32'(bin_index) >= 32'(BIN_COUNT)) begin
				cmd_job.op     = OP_PASS;
				cmd_job.status = ST_RANGE;
			end else begin
				cmd_job.op     = OP_READ;
				cmd_job.status = ST_READ;
			end
		end
	end

	assign q_push = (state_q == F_EVAL) || (accept && kind != KIND_PIXEL);
	assign q_job  = (state_q == F_EVAL) ? pix_job : cmd_job;

	// the left tap is compared through mt1; the oldest tap only ages out
	logic unused_tap;
	assign unused_tap = ^mt2_q;
endmodule

[design/ivh_queue.sv]
// Two-entry job queue between the front end and the back end.
module ivh_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  ivh_pkg::job_t wr_job,
	output logic          q_full,
	input  logic          rd,
	output ivh_pkg::job_t rd_job,
	output logic          q_empty
);
	import ivh_pkg::*;

	job_t       slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign q_full  = cnt_q == 2'd2;
	assign q_empty = cnt_q == 2'd0;
	assign rd_job  = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (wr) begin
			slot_q[wp_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) begin
				wp_q <= ~wp_q;
			end
			if (rd) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end
endmodule

[design/ivh_back.sv]
// Back end: bin counter memory, read-modify-write, clearing sweep and result register.
module ivh_back #(
	parameter int BIN_COUNT = ivh_pkg::DEF_BIN_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_empty,
	input  ivh_pkg::job_t                   q_job,
	output logic                            q_pop,
	output logic                            init_busy,
	input  logic                            pop,
	output logic                            empty,
	output logic [2:0]                      status,
	output logic [ivh_pkg::COUNT_BITS-1:0]  bin_count,
	output logic [ivh_pkg::BIN_PORT_W-1:0]  bin,
	output logic                            frame_end
);
	import ivh_pkg::*;

	localparam int BW = $clog2(BIN_COUNT);
	localparam logic [1:0] B_CLR  = 2'd0;
	localparam logic [1:0] B_IDLE = 2'd1;
	localparam logic [1:0] B_RD   = 2'd2;

	logic [COUNT_BITS-1:0] cnt_mem [BIN_COUNT];
	logic [1:0]            st_q;
	logic [BW-1:0]         clr_q;
	logic                  clr_emit_q;
	logic                  ovalid_q;
	job_t                  job_q;
	logic [COUNT_BITS-1:0] rd_q, inc;
	logic                  take, clr_last, we;
	logic [BW-1:0]         wa;
	logic                  ld;
	logic [2:0]            ld_status;
	logic [COUNT_BITS-1:0] ld_count;
	logic [BIN_PORT_W-1:0] ld_bin;
	logic                  ld_fe;

	assign take      = (st_q == B_IDLE) && !q_empty && !ovalid_q;
	assign q_pop     = take;
	assign clr_last  = clr_q == BW'(BIN_COUNT - 1);
	assign init_busy = (st_q == B_CLR) && !clr_emit_q;
	assign inc       = (rd_q == '1) ? rd_q : rd_q + COUNT_BITS'(1);
	assign we        = (st_q == B_CLR) || (st_q == B_RD && job_q.op == OP_COUNT);
	assign wa        = (st_q == B_CLR) ? clr_q : job_q.bin[BW-1:0];
	assign empty     = !ovalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			cnt_mem[wa] <= (st_q == B_CLR) ? '0 : inc;
		end
		if (take) begin
			rd_q <= cnt_mem[q_job.bin[BW-1:0]];
		end
	end

	always_comb begin
		ld        = 1'b0;
		ld_status = ST_CLEARED;
		ld_count  = '0;
		ld_bin    = '0;
		ld_fe     = 1'b0;
		case (st_q)
			B_IDLE: begin
				if (take && q_job.op == OP_PASS) begin
					ld        = 1'b1;
					ld_status = q_job.status;
					ld_bin    = q_job.bin[BIN_PORT_W-1:0];
					ld_fe     = q_job.frame_end;
				end
			end
			B_RD: begin
				ld        = 1'b1;
				ld_status = job_q.status;
				ld_count  = (job_q.op == OP_COUNT) ? inc : rd_q;
				ld_bin    = job_q.bin[BIN_PORT_W-1:0];
				ld_fe     = job_q.frame_end;
			end
			B_CLR: begin
				ld = clr_last && clr_emit_q;
			end
			default: begin
				ld = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (take) begin
			job_q <= q_job;
		end
		if (ld) begin
			status    <= ld_status;
			bin_count <= ld_count;
			bin       <= ld_bin;
			frame_end <= ld_fe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= B_CLR;
			clr_q      <= '0;
			clr_emit_q <= 1'b0;
			ovalid_q   <= 1'b0;
		end else begin
			if (ld) begin
				ovalid_q <= 1'b1;
			end else if (pop && ovalid_q) begin
				ovalid_q <= 1'b0;
			end
			case (st_q)
				B_IDLE: begin
					if (take && q_job.op == OP_CLEAR) begin
						st_q       <= B_CLR;
						clr_q      <= '0;
						clr_emit_q <= 1'b1;
					end else if (take && q_job.op != OP_PASS) begin
						st_q <= B_RD;
					end
				end
				B_RD: begin
					st_q <= B_IDLE;
				end
				B_CLR: begin
					clr_q <= clr_q + BW'(1);
					if (clr_last) begin
						st_q <= B_IDLE;
					end
				end
				default: begin
					st_q <= B_IDLE;
				end
			endcase
		end
	end
endmodule

[design/item_id_visibility_histogram.sv]
// Item ID visibility histogram: top level with configuration registers.
// A pixel word goes through the front end as a line buffer read, then a
// tap update and classification; a counted or read bin goes through the
// back end as a counter read, then, for a counted bin, a saturating increment
// and write back, and the back end takes its next job only once the result register has been
// popped. The front end takes no new word while it classifies a pixel, and
// the throughput is bounded by the single-port line buffers, the counter
// memory read-modify-write and the single result register. The front and
// back are joined by a two-entry queue, so words are still taken while a
// result waits. A clear-all word sweeps the counter memory one bin a cycle,
// over all BIN_COUNT bins (4096 by default), before its result appears; the
// same sweep runs after reset, and full stays high until it is done.
// Registers are to be written only while the block is idle; the user must
// keep to this, as the block itself does not enforce it.
module item_id_visibility_histogram #(
	parameter int MAX_WIDTH  = ivh_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = ivh_pkg::DEF_MAX_HEIGHT,
	parameter int BIN_COUNT  = ivh_pkg::DEF_BIN_COUNT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [ivh_pkg::ADDR_W-1:0]      paddr,
	input  logic [ivh_pkg::DATA_W-1:0]      pwdata,
	output logic [ivh_pkg::DATA_W-1:0]      prdata,
	output logic                            pready,
	input  logic                            push,
	output logic                            full,
	input  logic [1:0]                      kind,
	input  logic [ivh_pkg::ID_W-1:0]        pixel_id,
	input  logic [11:0]                     bin_index,
	input  logic                            pop,
	output logic                            empty,
	output logic [2:0]                      status,
	output logic [ivh_pkg::COUNT_BITS-1:0]  bin_count,
	output logic [ivh_pkg::BIN_PORT_W-1:0]  bin,
	output logic                            frame_end
);
	import ivh_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] ridx;
	logic       q_full, q_empty, q_push, q_pop, hold;
	job_t       push_job, pop_job;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign ridx   = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.conservative <= 1'b0;
			cfg_q.two_level    <= 1'b0;
			cfg_q.width        <= 11'd1024;
			cfg_q.height       <= 11'd1024;
			cfg_q.item_limit   <= 13'd4096;
			cfg_q.group_limit  <= 7'd64;
			cfg_q.member_limit <= 7'd64;
		end else if (wr_en) begin
			case (ridx)
				REG_CONS:    cfg_q.conservative <= pwdata[0];
				REG_LAYOUT:  cfg_q.two_level    <= pwdata[0];
				REG_WIDTH:   cfg_q.width        <= pwdata[10:0];
				REG_HEIGHT:  cfg_q.height       <= pwdata[10:0];
				REG_ITEMS:   cfg_q.item_limit   <= pwdata[12:0];
				REG_GROUPS:  cfg_q.group_limit  <= pwdata[6:0];
				REG_MEMBERS: cfg_q.member_limit <= pwdata[6:0];
				default:     cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_CONS:    prdata = DATA_W'(cfg_q.conservative);
			REG_LAYOUT:  prdata = DATA_W'(cfg_q.two_level);
			REG_WIDTH:   prdata = DATA_W'(cfg_q.width);
			REG_HEIGHT:  prdata = DATA_W'(cfg_q.height);
			REG_ITEMS:   prdata = DATA_W'(cfg_q.item_limit);
			REG_GROUPS:  prdata = DATA_W'(cfg_q.group_limit);
			REG_MEMBERS: prdata = DATA_W'(cfg_q.member_limit);
			default:     prdata = '0;
		endcase
	end

	ivh_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.BIN_COUNT (BIN_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.push     (push),
		.full     (full),
		.kind     (kind),
		.pixel_id (pixel_id),
		.bin_index(bin_index),
		.hold     (hold),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	ivh_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_job (push_job),
		.q_full (q_full),
		.rd     (q_pop),
		.rd_job (pop_job),
		.q_empty(q_empty)
	);

	ivh_back #(
		.BIN_COUNT(BIN_COUNT)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_job    (pop_job),
		.q_pop    (q_pop),
		.init_busy(hold),
		.pop      (pop),
		.empty    (empty),
		.status   (status),
		.bin_count(bin_count),
		.bin      (bin),
		.frame_end(frame_end)
	);
endmodule

[design/ivh_checker.sv]
// Port-level checker for the item ID visibility histogram, bound to the top level.
`include "item_id_visibility_histogram_macros.svh"
module ivh_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            push,
	input logic                            full,
	input logic                            pop,
	input logic                            empty,
	input logic [2:0]                      status,
	input logic [ivh_pkg::COUNT_BITS-1:0]  bin_count,
	input logic [ivh_pkg::BIN_PORT_W-1:0]  bin,
	input logic                            frame_end
);
	import ivh_pkg::*;

	`IVH_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(status) && $stable(bin), "result word changed while waiting")
	`IVH_ASSERT_NOW(a_zero_count, !empty && status != ST_COUNTED && status != ST_READ, bin_count == '0, "nonzero count on a word without a bin")
	`IVH_ASSERT_NOW(a_counted_nonzero, !empty && status == ST_COUNTED, bin_count != '0, "counted bin reports zero")
	`IVH_ASSERT_NOW(a_frame_end_pixel, !empty && frame_end, status != ST_READ && status != ST_CLEARED, "frame end on a command word")
endmodule

bind item_id_visibility_histogram ivh_checker u_ivh_checker (.*);

[sim/tb_top.sv]
// Testbench for the item ID visibility histogram: directed and random words, checked in order.
`timescale 1ns / 1ps
module tb_top;
	import ivh_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int LINE_MAX = 1024;
	localparam int BINS = 4096;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [2:0]  status;
		logic [20:0] count;
		logic [11:0] bin;
		logic        fe;
	} hist_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic push = 1'b0;
	logic full;
	logic [1:0] kind = KIND_PIXEL;
	logic [31:0] pixel_id = '0;
	logic [11:0] bin_index = '0;
	logic pop = 1'b0;
	logic empty;
	logic [2:0] status;
	logic [20:0] bin_count;
	logic [11:0] bin;
	logic frame_end;

	item_id_visibility_histogram dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic        cfg_cons = 1'b0, cfg_two = 1'b0;
	logic [10:0] cfg_w = 11'd1024, cfg_h = 11'd1024;
	logic [12:0] cfg_items = 13'd4096;
	logic [6:0]  cfg_groups = 7'd64, cfg_members = 7'd64;
	logic [31:0] line_one [LINE_MAX];
	logic [31:0] line_two [LINE_MAX];
	logic [31:0] mid_taps [3];
	logic [31:0] up_tap, cur_prev;
	int          col_pos, row_pos;
	logic [20:0] tallies [BINS];

	hist_result_t pending_results [$];
	logic [31:0]  palette [4];
	logic [11:0]  last_bin = '0;
	int send_gap_max = 10, rcv_stall_max = 10, hold_req = 0;
	int mismatches = 0, results_seen = 0, counted_seen = 0, frames_seen = 0, words_sent = 0;
	int idle_cycles = 0;

	initial begin
		foreach (line_one[i]) begin
			line_one[i] = '0;
			line_two[i] = '0;
		end
		foreach (tallies[i]) tallies[i] = '0;
		foreach (mid_taps[i]) mid_taps[i] = NULL_ID;
		up_tap = NULL_ID;
		cur_prev = NULL_ID;
		col_pos = 0;
		row_pos = 0;
	end

	function automatic int clamp_dim(input logic [10:0] v);
		if (v == 0) return 1;
		return (v > LINE_MAX) ? LINE_MAX : int'(v);
	endfunction

	task automatic tally_id(input logic [31:0] id, inout hist_result_t r);
		logic [15:0] grp, mem;
		logic ok;
		logic [11:0] b;
		grp = id[15:0];
		mem = id[31:16];
		if (id == NULL_ID) begin
			r.status = ST_NULL;
			return;
		end
		if (cfg_two) begin
			ok = grp < cfg_groups && mem < cfg_members && grp < 64 && mem < 64;
			b = {grp[5:0], mem[5:0]};
		end else begin
			ok = id < cfg_items && id < BINS;
			b = id[11:0];
		end
		if (!ok) begin
			r.status = ST_RANGE;
			return;
		end
		if (tallies[b] != '1) tallies[b] = tallies[b] + 1'b1;
		r.status = ST_COUNTED;
		r.count = tallies[b];
		r.bin = b;
		last_bin = b;
	endtask

	task automatic predict_word(input logic [1:0] k, input logic [31:0] id, input logic [11:0] idx);
		hist_result_t r;
		logic [31:0] above, two_above, top, bottom, ctr;
		int c;
		r = '0;
		if (k == KIND_CLEAR) begin
			foreach (tallies[i]) tallies[i] = '0;
			r.status = ST_CLEARED;
		end else if (k != KIND_PIXEL) begin
			r.status = ST_READ;
			r.bin = idx;
			r.count = tallies[idx];
		end else begin
			c = col_pos;
			above = line_one[c];
			two_above = line_two[c];
			mid_taps[2] = mid_taps[1];
			mid_taps[1] = mid_taps[0];
			mid_taps[0] = above;
			top = up_tap;
			up_tap = two_above;
			bottom = cur_prev;
			cur_prev = id;
			line_two[c] = above;
			line_one[c] = id;
			if (cfg_cons) begin
				ctr = mid_taps[1];
				if (row_pos < 2 || c < 2) r.status = ST_BORDER;
				else if (ctr == NULL_ID) r.status = ST_NULL;
				else if (top != ctr || bottom != ctr || mid_taps[2] != ctr || mid_taps[0] != ctr)
					r.status = ST_BORDER;
				else tally_id(ctr, r);
			end else begin
				tally_id(id, r);
			end
			if (c + 1 >= clamp_dim(cfg_w)) begin
				col_pos = 0;
				if (row_pos + 1 >= clamp_dim(cfg_h)) begin
					row_pos = 0;
					r.fe = 1'b1;
				end else row_pos = row_pos + 1;
			end else col_pos = c + 1;
		end
		pending_results.push_back(r);
	endtask

	task automatic send_word(input logic [1:0] k, input logic [31:0] id, input logic [11:0] idx);
		int gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		kind <= k;
		pixel_id <= id;
		bin_index <= idx;
		push <= 1'b1;
		do @(posedge clk); while (full);
		predict_word(k, id, idx);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		push <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_CONS:    cfg_cons = value[0];
			REG_LAYOUT:  cfg_two = value[0];
			REG_WIDTH:   cfg_w = value[10:0];
			REG_HEIGHT:  cfg_h = value[10:0];
			REG_ITEMS:   cfg_items = value[12:0];
			REG_GROUPS:  cfg_groups = value[6:0];
			REG_MEMBERS: cfg_members = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [31:0] valid_id();
		if (cfg_two) return {16'($urandom_range(0, cfg_members - 1)),
			16'($urandom_range(0, cfg_groups - 1))};
		return 32'($urandom_range(0, ((cfg_items > BINS) ? BINS : cfg_items) - 1));
	endfunction

	function automatic logic [31:0] pick_id();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8) return NULL_ID;
		if (r < 16) return $urandom;
		if (r < 22) begin
			if (cfg_two) return {16'(cfg_members - $urandom_range(0, 1)),
				16'(cfg_groups - $urandom_range(0, 1))};
			return 32'(cfg_items - $urandom_range(0, 1));
		end
		return palette[((col_pos >> 2) ^ (row_pos >> 2)) & 3];
	endfunction

	task automatic new_palette();
		foreach (palette[i]) palette[i] = valid_id();
	endtask

	task automatic finish_frame();
		while (col_pos != 0 || row_pos != 0) send_word(KIND_PIXEL, pick_id(), 12'($urandom));
	endtask

	task automatic set_config(input logic cons, input logic two, input logic [10:0] w,
		input logic [10:0] h, input logic [12:0] items, input logic [6:0] groups,
		input logic [6:0] members);
		finish_frame();
		drain();
		reg_write(REG_CONS, 32'(cons));
		reg_write(REG_LAYOUT, 32'(two));
		reg_write(REG_WIDTH, 32'(w));
		reg_write(REG_HEIGHT, 32'(h));
		reg_write(REG_ITEMS, 32'(items));
		reg_write(REG_GROUPS, 32'(groups));
		reg_write(REG_MEMBERS, 32'(members));
		new_palette();
	endtask

	task automatic random_words(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 85) send_word(KIND_PIXEL, pick_id(), 12'($urandom));
			else if (r < 99) send_word($urandom_range(0, 1) ? KIND_READ : KIND_SPARE, $urandom,
				$urandom_range(0, 1) ? 12'($urandom) : last_bin);
			else send_word(KIND_CLEAR, $urandom, 12'($urandom));
		end
	endtask

	task automatic test_simple_directed();
		set_config(1'b0, 1'b0, 11'd4, 11'd3, 13'd4096, 7'd64, 7'd64);
		send_word(KIND_PIXEL, 32'd0, 12'hfff);
		send_word(KIND_PIXEL, 32'd4095, 12'h000);
		send_word(KIND_PIXEL, 32'd4096, 12'h000);
		send_word(KIND_PIXEL, NULL_ID, 12'h000);
		send_word(KIND_PIXEL, 32'hffff_fffe, 12'h000);
		send_word(KIND_PIXEL, 32'd0, 12'h000);
		send_word(KIND_READ, 32'd0, 12'd0);
		send_word(KIND_READ, 32'd0, 12'd4095);
		send_word(KIND_SPARE, 32'd0, 12'd0);
		send_word(KIND_CLEAR, 32'd0, 12'd0);
		send_word(KIND_READ, NULL_ID, 12'd0);
		set_config(1'b0, 1'b1, 11'd3, 11'd2, 13'd1, 7'd64, 7'd64);
		send_word(KIND_PIXEL, {16'd63, 16'd63}, 12'd0);
		send_word(KIND_PIXEL, {16'd0, 16'd64}, 12'd0);
		send_word(KIND_PIXEL, {16'd64, 16'd0}, 12'd0);
		send_word(KIND_PIXEL, {16'd0, 16'd0}, 12'd0);
		send_word(KIND_READ, 32'd0, 12'd4095);
		set_config(1'b0, 1'b0, 11'd3, 11'd2, 13'd1, 7'd1, 7'd1);
		send_word(KIND_PIXEL, 32'd0, 12'd0);
		send_word(KIND_PIXEL, 32'd1, 12'd0);
	endtask

	task automatic test_conservative_directed();
		set_config(1'b1, 1'b0, 11'd5, 11'd5, 13'd4096, 7'd64, 7'd64);
		repeat (25) send_word(KIND_PIXEL, 32'd7, 12'd0);
		repeat (25) send_word(KIND_PIXEL, NULL_ID, 12'd0);
		for (int i = 0; i < 25; i++) send_word(KIND_PIXEL, (i == 12) ? 32'd9 : 32'd7, 12'd0);
		send_word(KIND_READ, 32'd0, 12'd7);
	endtask

	task automatic test_geometry_extremes();
		set_config(1'b0, 1'b0, 11'd2047, 11'd1, 13'd4096, 7'd64, 7'd64);
		repeat (LINE_MAX) send_word(KIND_PIXEL, 32'd5, 12'($urandom));
		set_config(1'b0, 1'b0, 11'd0, 11'd0, 13'd4096, 7'd64, 7'd64);
		repeat (4) send_word(KIND_PIXEL, 32'd5, 12'($urandom));
		set_config(1'b0, 1'b0, 11'd1, 11'd6, 13'd4096, 7'd64, 7'd64);
		repeat (8) send_word(KIND_PIXEL, pick_id(), 12'($urandom));
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 8; ph++) begin
			send_gap_max = (ph == 3) ? 0 : 10;
			rcv_stall_max = (ph == 3 || ph == 5) ? 0 : 10;
			set_config(1'($urandom), 1'($urandom), 11'($urandom_range(1, 16)),
				11'($urandom_range(1, 8)), 13'($urandom_range(1, 4096)),
				7'($urandom_range(1, 64)), 7'($urandom_range(1, 64)));
			random_words(60);
		end
		send_gap_max = 10;
		rcv_stall_max = 10;
	endtask

	task automatic test_backpressure();
		set_config(1'b1, 1'b1, 11'd8, 11'd6, 13'd4096, 7'd64, 7'd64);
		send_gap_max = 0;
		hold_req = 300;
		random_words(60);
		send_gap_max = 10;
		random_words(20);
		drain();
		random_words(20);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_simple_directed();
		test_conservative_directed();
		test_geometry_extremes();
		test_random();
		test_backpressure();
		drain();
		repeat (20) @(posedge clk);
		$display("words sent %0d, results checked %0d, counted %0d, frames ended %0d",
			words_sent, results_seen, counted_seen, frames_seen);
		$display("both modes and layouts, border geometry, reads, clears and stalls covered");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

	initial begin
		int stall;
		hist_result_t got, want;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, rcv_stall_max);
			if (hold_req > 0) begin
				stall = stall + hold_req;
				hold_req = 0;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			pop <= 1'b1;
			do @(posedge clk); while (empty);
			got = {status, bin_count, bin, frame_end};
			results_seen++;
			if (got.status == ST_COUNTED) counted_seen++;
			if (got.fe) frames_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word: status %0d count %0d bin %0d fe %0d",
					got.status, got.count, got.bin, got.fe);
			end else begin
				want = pending_results.pop_front();
				if (got != want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st %0d cnt %0d bin %0d fe %0d, got st %0d cnt %0d bin %0d fe %0d",
							want.status, want.count, want.bin, want.fe,
							got.status, got.count, got.bin, got.fe);
				end
			end
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb_top NOT OK");
				$finish;
			end
		end
	end
endmodule
